[hdl/lkc_pkg.sv]
`default_nettype none

package lkc_pkg;

  // default cache size
  localparam int ENTRIES_DEF = 64;

  // field widths
  localparam int OP_W      = 2;
  localparam int FONT_W    = 16;
  localparam int CP_W      = 21;
  localparam int SIZE_W    = 10;
  localparam int KEY_W     = FONT_W + CP_W + SIZE_W;
  localparam int PAYLOAD_W = 48;
  localparam int OCC_W     = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture the input transaction
    logic clear;      // drop all entries
    logic scan_run;   // key search pass over the held entries
    logic upd_start;  // latch the update plan
    logic upd_run;    // recency update pass
    logic resp_set;   // load the result register
  } lkc_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic pass_done;  // current memory pass has drained
    logic need_upd;   // plan calls for an update pass
    logic out_free;   // result register can take a new result
  } lkc_sts_t;

endpackage

`default_nettype wire

[hdl/lkc_ram.sv]
`default_nettype none

module lkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/lkc_ctrl.sv]
`default_nettype none

module lkc_ctrl
  import lkc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [OP_W-1:0] in_operation,
  output logic                 in_ready,
  input  wire lkc_sts_t        sts,
  output lkc_cmd_t             cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_PLAN = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // sequencing of one transaction
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          priority if (in_operation == OP_LOOKUP || in_operation == OP_INSERT) begin
            state_nxt = ST_SCAN;
          end else if (in_operation == OP_CLEAR) begin
            cmd.clear = 1'b1;
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.pass_done) begin
          state_nxt = ST_PLAN;
        end
      end
      ST_PLAN: begin
        if (sts.need_upd) begin
          cmd.upd_start = 1'b1;
          state_nxt     = ST_UPD;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_UPD: begin
        cmd.upd_run = 1'b1;
        if (sts.pass_done) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.resp_set = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/lkc_dp.sv]
`default_nettype none

module lkc_dp
  import lkc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lkc_cmd_t             cmd,
  output lkc_sts_t                  sts,
  input  wire logic [OP_W-1:0]      in_operation,
  input  wire logic [FONT_W-1:0]    in_font_id,
  input  wire logic [CP_W-1:0]      in_char_code,
  input  wire logic [SIZE_W-1:0]    in_pixel_size,
  input  wire logic [PAYLOAD_W-1:0] in_payload,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_hit,
  output logic [PAYLOAD_W-1:0]      out_hit_payload,
  output logic [OCC_W-1:0]          out_occupancy
);

  localparam int AW     = $clog2(ENTRIES);
  localparam int CW     = $clog2(ENTRIES + 1);
  localparam int WORD_W = AW + PAYLOAD_W + KEY_W;

  // captured transaction
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [PAYLOAD_W-1:0] pay_r, pay_nxt;

  // entries are always held in slots 0 to count-1
  logic [CW-1:0]        count_r, count_nxt;

  // memory pass pointers
  logic [CW-1:0]        rd_idx_r, rd_idx_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]        chk_idx_r, chk_idx_nxt;

  // search results
  logic                 found_r, found_nxt;
  logic [AW-1:0]        match_idx_r, match_idx_nxt;
  logic [AW-1:0]        match_rank_r, match_rank_nxt;
  logic [PAYLOAD_W-1:0] match_pay_r, match_pay_nxt;
  logic [AW-1:0]        victim_idx_r, victim_idx_nxt;

  // update plan
  logic [AW-1:0]        tgt_idx_r, tgt_idx_nxt;
  logic [AW-1:0]        tgt_rank_r, tgt_rank_nxt;
  logic [CW-1:0]        upd_end_r, upd_end_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [PAYLOAD_W-1:0] out_pay_r, out_pay_nxt;
  logic [OCC_W-1:0]     out_occ_r, out_occ_nxt;

  // memory ports
  logic                 ram_we;
  logic [WORD_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [WORD_W-1:0]    ram_rdata;

  // fields of the word read back
  logic [KEY_W-1:0]     rd_key;
  logic [PAYLOAD_W-1:0] rd_pay;
  logic [AW-1:0]        rd_rank;

  logic                 pass_run;
  logic [CW-1:0]        pass_end;
  logic                 full;
  logic [AW-1:0]        last_rank;

  logic                 plan_upd;
  logic [AW-1:0]        plan_idx;
  logic [AW-1:0]        plan_rank;
  logic [CW-1:0]        plan_end;

  logic [KEY_W-1:0]     new_key;
  logic [PAYLOAD_W-1:0] new_pay;
  logic [AW-1:0]        aged_rank;

  assign rd_key  = ram_rdata[KEY_W-1:0];
  assign rd_pay  = ram_rdata[KEY_W +: PAYLOAD_W];
  assign rd_rank = ram_rdata[KEY_W + PAYLOAD_W +: AW];

  // one read per cycle over slots 0 to pass_end-1
  assign pass_run  = cmd.scan_run | cmd.upd_run;
  assign pass_end  = cmd.upd_run ? upd_end_r : count_r;
  assign ram_re    = pass_run && (rd_idx_r < pass_end);
  assign full      = (count_r == CW'(ENTRIES));
  assign last_rank = AW'(count_r - CW'(1));

  // decide target slot, its old rank and the new entry count
  always_comb begin
    plan_upd  = found_r;
    plan_idx  = match_idx_r;
    plan_rank = match_rank_r;
    plan_end  = count_r;
    if (op_r == OP_INSERT) begin
      plan_upd = 1'b1;
      if (!found_r) begin
        if (full) begin
          // least recent entry gives up its slot
          plan_idx  = victim_idx_r;
          plan_rank = AW'(ENTRIES - 1);
        end else begin
          // first free slot, every held entry ages by one
          plan_idx  = count_r[AW-1:0];
          plan_rank = count_r[AW-1:0];
          plan_end  = count_r + CW'(1);
        end
      end
    end
  end

  // write back of the update pass
  always_comb begin
    new_key   = (op_r == OP_INSERT) ? key_r : rd_key;
    new_pay   = (op_r == OP_INSERT) ? pay_r : rd_pay;
    aged_rank = (rd_rank < tgt_rank_r) ? rd_rank + AW'(1) : rd_rank;
    ram_we    = cmd.upd_run && chk_vld_r;
    if (chk_idx_r == tgt_idx_r) begin
      ram_wdata = {AW'(0), new_pay, new_key};
    end else begin
      ram_wdata = {aged_rank, rd_pay, rd_key};
    end
  end

  assign sts.pass_done = !ram_re && !chk_vld_r;
  assign sts.need_upd  = plan_upd;
  assign sts.out_free  = !out_valid_r || out_ready;

  // next state of the datapath registers
  always_comb begin
    op_nxt         = op_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    found_nxt      = found_r;
    match_idx_nxt  = match_idx_r;
    match_rank_nxt = match_rank_r;
    match_pay_nxt  = match_pay_r;
    victim_idx_nxt = victim_idx_r;
    tgt_idx_nxt    = tgt_idx_r;
    tgt_rank_nxt   = tgt_rank_r;
    upd_end_nxt    = upd_end_r;
    out_valid_nxt  = out_valid_r;
    out_hit_nxt    = out_hit_r;
    out_pay_nxt    = out_pay_r;
    out_occ_nxt    = out_occ_r;

    // capture the transaction and rewind the pass
    if (cmd.load) begin
      op_nxt      = in_operation;
      key_nxt     = {in_font_id, in_char_code, in_pixel_size};
      pay_nxt     = in_payload;
      rd_idx_nxt  = '0;
      chk_vld_nxt = 1'b0;
      found_nxt   = 1'b0;
    end
    if (cmd.clear) begin
      count_nxt = '0;
    end

    // read pointer and read-data tag
    if (pass_run) begin
      chk_vld_nxt = ram_re;
      chk_idx_nxt = rd_idx_r[AW-1:0];
      if (ram_re) begin
        rd_idx_nxt = rd_idx_r + CW'(1);
      end
    end

    // key compare and victim search
    if (cmd.scan_run && chk_vld_r) begin
      if (rd_key == key_r) begin
        found_nxt      = 1'b1;
        match_idx_nxt  = chk_idx_r;
        match_rank_nxt = rd_rank;
        match_pay_nxt  = rd_pay;
      end
      if (rd_rank == last_rank) begin
        victim_idx_nxt = chk_idx_r;
      end
    end

    // latch the plan and rewind for the update pass
    if (cmd.upd_start) begin
      tgt_idx_nxt  = plan_idx;
      tgt_rank_nxt = plan_rank;
      upd_end_nxt  = plan_end;
      count_nxt    = plan_end;
      rd_idx_nxt   = '0;
      chk_vld_nxt  = 1'b0;
    end

    // result register
    if (cmd.resp_set) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = (op_r == OP_LOOKUP) && found_r;
      out_pay_nxt   = ((op_r == OP_LOOKUP) && found_r) ? match_pay_r : '0;
      out_occ_nxt   = OCC_W'(count_r);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_idx_r    <= '0;
      chk_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    chk_idx_r    <= chk_idx_nxt;
    match_idx_r  <= match_idx_nxt;
    match_rank_r <= match_rank_nxt;
    match_pay_r  <= match_pay_nxt;
    victim_idx_r <= victim_idx_nxt;
    tgt_idx_r    <= tgt_idx_nxt;
    tgt_rank_r   <= tgt_rank_nxt;
    upd_end_r    <= upd_end_nxt;
    out_hit_r    <= out_hit_nxt;
    out_pay_r    <= out_pay_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  // entry store: {rank, payload, key}
  lkc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (chk_idx_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_hit_payload = out_pay_r;
  assign out_occupancy   = out_occ_r;

endmodule

`default_nettype wire

[hdl/lru_keyed_entry_cache.sv]
`default_nettype none

// Fully associative LRU cache of up to ENTRIES glyph entries, keyed by
// {font_id, char_code, pixel_size} with a 48-bit descriptor each. One
// transaction is handled at a time; every transaction gives one result with
// the occupancy after it. Entries sit in one single-port-read memory that
// holds key, payload and recency rank. A lookup or insert walks it at one
// entry per cycle: a search pass over the N held entries, then, on a hit or
// an insert, a rank update pass. Clear and an unused operation code do not
// walk the memory. A result waiting with out_ready low holds the block back.
// The next transaction can be accepted in the cycle after its result is
// loaded, while that result still waits in the output register.
// No clearing pass is needed after reset.
module lru_keyed_entry_cache
  import lkc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [OP_W-1:0]      in_operation,
  input  wire logic [FONT_W-1:0]    in_font_id,
  input  wire logic [CP_W-1:0]      in_char_code,
  input  wire logic [SIZE_W-1:0]    in_pixel_size,
  input  wire logic [PAYLOAD_W-1:0] in_payload,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_hit,
  output logic [PAYLOAD_W-1:0]      out_hit_payload,
  output logic [OCC_W-1:0]          out_occupancy
);

  lkc_cmd_t cmd;
  lkc_sts_t sts;

  // sequencer
  lkc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // entry store, search and update
  lkc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_font_id      (in_font_id),
    .in_char_code    (in_char_code),
    .in_pixel_size   (in_pixel_size),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_hit_payload (out_hit_payload),
    .out_occupancy   (out_occupancy)
  );

`ifndef ASSERT_OFF
  // one transaction in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("transaction accepted while another is in flight");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp_set |-> sts.out_free)
    else $error("result register overwritten");

  // update plan follows a finished search pass
  a_plan_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_start |-> ($past(cmd.scan_run) && $past(sts.pass_done)))
    else $error("update started without a finished search");
`endif

endmodule

`default_nettype wire

[tb/glyph_cache_checker.sv]
`timescale 1ns / 1ps

module glyph_cache_checker
  import lkc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic [OP_W-1:0]      in_operation,
  input  wire logic [FONT_W-1:0]    in_font_id,
  input  wire logic [CP_W-1:0]      in_char_code,
  input  wire logic [SIZE_W-1:0]    in_pixel_size,
  input  wire logic [PAYLOAD_W-1:0] in_payload,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic                 out_hit,
  input  wire logic [PAYLOAD_W-1:0] out_hit_payload,
  input  wire logic [OCC_W-1:0]     out_occupancy,
  output int                        fail_count,
  output int                        pending,
  output int                        results_seen,
  output int                        lookup_hits,
  output int                        lookup_misses,
  output int                        evictions,
  output int                        replacements,
  output int                        clears,
  output int                        idle_ops
);

  typedef struct packed {
    logic                 hit;
    logic [PAYLOAD_W-1:0] payload;
    logic [OCC_W-1:0]     occupancy;
  } cache_result_t;

  // results still owed by the block, oldest first
  cache_result_t expected_results[$];
  cache_result_t want;

  // shadow copy of the cache contents
  logic                 slot_valid   [ENTRIES];
  logic [KEY_W-1:0]     slot_key     [ENTRIES];
  logic [PAYLOAD_W-1:0] slot_payload [ENTRIES];
  int unsigned          slot_rank    [ENTRIES];
  int unsigned          held;

  initial begin
    fail_count    = 0;
    pending       = 0;
    results_seen  = 0;
    lookup_hits   = 0;
    lookup_misses = 0;
    evictions     = 0;
    replacements  = 0;
    clears        = 0;
    idle_ops      = 0;
  end

  task automatic report_fault(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void empty_cache();
    for (int i = 0; i < ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_rank[i]  = 0;
    end
    held = 0;
  endfunction

  function automatic int find_slot(input logic [KEY_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_key[i] == key) return i;
    end
    return ENTRIES;
  endfunction

  // slot becomes newest, the ones newer than it age by one
  function automatic void make_newest(input int s);
    int unsigned r;
    r = slot_rank[s];
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  // oldest entry goes, ties resolve to the highest slot
  function automatic void evict_oldest();
    int          victim;
    int unsigned oldest;
    victim = -1;
    oldest = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && (victim < 0 || slot_rank[i] >= oldest)) begin
        victim = i;
        oldest = slot_rank[i];
      end
    end
    if (victim >= 0) begin
      slot_valid[victim] = 1'b0;
      if (held > 0) held--;
      evictions++;
    end
  endfunction

  function automatic void insert_entry(input logic [KEY_W-1:0] key,
                                       input logic [PAYLOAD_W-1:0] payload);
    int s;
    s = find_slot(key);
    if (s < ENTRIES) begin
      slot_payload[s] = payload;
      make_newest(s);
      replacements++;
      return;
    end
    if (held >= ENTRIES) evict_oldest();
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i]) slot_rank[i]++;
    end
    // new entry takes the lowest free slot
    for (int i = 0; i < ENTRIES; i++) begin
      if (!slot_valid[i]) begin
        slot_valid[i]   = 1'b1;
        slot_key[i]     = key;
        slot_payload[i] = payload;
        slot_rank[i]    = 0;
        held++;
        return;
      end
    end
  endfunction

  function automatic cache_result_t predict_cache_result(input logic [OP_W-1:0] op,
                                                         input logic [KEY_W-1:0] key,
                                                         input logic [PAYLOAD_W-1:0] payload);
    cache_result_t r;
    int            s;
    r.hit     = 1'b0;
    r.payload = '0;
    case (op)
      OP_LOOKUP: begin
        s = find_slot(key);
        if (s < ENTRIES) begin
          r.hit     = 1'b1;
          r.payload = slot_payload[s];
          make_newest(s);
          lookup_hits++;
        end else begin
          lookup_misses++;
        end
      end
      OP_INSERT: insert_entry(key, payload);
      OP_CLEAR: begin
        empty_cache();
        clears++;
      end
      default: idle_ops++;
    endcase
    r.occupancy = held[OCC_W-1:0];
    return r;
  endfunction

  // watch both channels, results are checked before new work is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      empty_cache();
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_fault($sformatf("result %0d with no transaction outstanding", results_seen));
        end else begin
          want = expected_results.pop_front();
          if (out_hit !== want.hit)
            report_fault($sformatf("result %0d hit: expected %0b, got %0b",
                                   results_seen, want.hit, out_hit));
          if (out_hit_payload !== want.payload)
            report_fault($sformatf("result %0d hit_payload: expected %0h, got %0h",
                                   results_seen, want.payload, out_hit_payload));
          if (out_occupancy !== want.occupancy)
            report_fault($sformatf("result %0d occupancy: expected %0d, got %0d",
                                   results_seen, want.occupancy, out_occupancy));
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_cache_result(
          in_operation, {in_font_id, in_char_code, in_pixel_size}, in_payload));
    end
    pending = expected_results.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import lkc_pkg::*;

  localparam int CACHE_ENTRIES = ENTRIES_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int KEY_POOL = 100;
  localparam int STUCK_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 2 * CACHE_ENTRIES + 64;

  logic clk = 1'b0;
  logic rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation;
  logic [FONT_W-1:0]    in_font_id;
  logic [CP_W-1:0]      in_char_code;
  logic [SIZE_W-1:0]    in_pixel_size;
  logic [PAYLOAD_W-1:0] in_payload;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_hit;
  logic [PAYLOAD_W-1:0] out_hit_payload;
  logic [OCC_W-1:0]     out_occupancy;

  int fail_count, pending, results_seen, lookup_hits, lookup_misses;
  int evictions, replacements, clears, idle_ops;

  int send_idle_pct;
  int stall_pct;
  int stuck_cycles;

  // keys that recur so lookups find something
  logic [FONT_W-1:0] pool_font [KEY_POOL];
  logic [CP_W-1:0]   pool_cp   [KEY_POOL];
  logic [SIZE_W-1:0] pool_size [KEY_POOL];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lru_keyed_entry_cache #(.ENTRIES(CACHE_ENTRIES)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_font_id      (in_font_id),
    .in_char_code    (in_char_code),
    .in_pixel_size   (in_pixel_size),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_hit_payload (out_hit_payload),
    .out_occupancy   (out_occupancy)
  );

  glyph_cache_checker #(.ENTRIES(CACHE_ENTRIES)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_font_id      (in_font_id),
    .in_char_code    (in_char_code),
    .in_pixel_size   (in_pixel_size),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_hit_payload (out_hit_payload),
    .out_occupancy   (out_occupancy),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_seen    (results_seen),
    .lookup_hits     (lookup_hits),
    .lookup_misses   (lookup_misses),
    .evictions       (evictions),
    .replacements    (replacements),
    .clears          (clears),
    .idle_ops        (idle_ops)
  );

  // result side back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // give up when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results owed",
                 STUCK_LIMIT, pending);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // one transaction, valid held until accepted
  task automatic send_op(input logic [OP_W-1:0] op, input logic [FONT_W-1:0] font,
                         input logic [CP_W-1:0] cp, input logic [SIZE_W-1:0] size,
                         input logic [PAYLOAD_W-1:0] payload);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_font_id    <= font;
    in_char_code  <= cp;
    in_pixel_size <= size;
    in_payload    <= payload;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // mostly lookups and inserts over the key pool, a few stray keys
  task automatic send_random(input int pool_n);
    int                   sel;
    int                   k;
    logic [OP_W-1:0]      op;
    logic [PAYLOAD_W-1:0] pl;
    sel = $urandom_range(0, 999);
    if (sel < 520)      op = OP_LOOKUP;
    else if (sel < 985) op = OP_INSERT;
    else if (sel < 997) op = OP_UNUSED;
    else                op = OP_CLEAR;
    pl = {16'($urandom), 32'($urandom)};
    if ($urandom_range(0, 99) < 8) begin
      send_op(op, 16'($urandom), 21'($urandom_range(0, 1114111)),
              10'($urandom), pl);
    end else begin
      k = $urandom_range(0, pool_n - 1);
      send_op(op, pool_font[k], pool_cp[k], pool_size[k], pl);
    end
  endtask

  task automatic run_phase(input int items, input int pool_n,
                           input int idle_pct, input int busy_pct);
    send_idle_pct = idle_pct;
    stall_pct     = busy_pct;
    repeat (items) send_random(pool_n);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = OP_LOOKUP;
    in_font_id    = '0;
    in_char_code  = '0;
    in_pixel_size = '0;
    in_payload    = '0;
    out_ready     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    stuck_cycles  = 0;

    // pool keys share fields often so near misses occur
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_font[i] = (i % 3 == 0) ? 16'($urandom) : 16'(i % 4);
      pool_cp[i]   = (i % 2 == 0) ? 21'($urandom_range(0, 1114111)) : 21'(i % 5);
      pool_size[i] = 10'($urandom);
    end

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty cache, key extremes, replace in place, unused code, clear
    send_op(OP_LOOKUP, '0, '0, '0, '1);
    send_op(OP_INSERT, '0, '0, '0, '0);
    send_op(OP_INSERT, 16'hFFFF, 21'h10FFFF, 10'h3FF, '1);
    send_op(OP_LOOKUP, '0, '0, '0, '1);
    send_op(OP_LOOKUP, 16'hFFFF, 21'h10FFFF, 10'h3FF, '0);
    send_op(OP_INSERT, '0, '0, '0, 48'hA5A5_5A5A_C3C3);
    send_op(OP_LOOKUP, '0, '0, '0, '0);
    send_op(OP_LOOKUP, 16'hFFFF, 21'h0FFFFF, 10'h3FF, '0);
    send_op(OP_LOOKUP, 16'hFFFF, 21'h10FFFF, 10'h3FE, '0);
    send_op(OP_UNUSED, 16'hFFFF, 21'h10FFFF, 10'h3FF, '1);
    send_op(OP_LOOKUP, 16'hFFFF, 21'h10FFFF, 10'h3FF, '0);
    send_op(OP_INSERT, 16'h1234, 21'h00ABCD, 10'h010, 48'h0000_0000_0001);
    send_op(OP_LOOKUP, 16'h1234, 21'h00ABCD, 10'h010, '0);
    send_op(OP_CLEAR, 16'hFFFF, 21'h10FFFF, 10'h3FF, '1);
    send_op(OP_LOOKUP, 16'hFFFF, 21'h10FFFF, 10'h3FF, '0);
    send_op(OP_CLEAR, '0, '0, '0, '0);
    send_op(OP_INSERT, 16'hFFFF, 21'h10FFFF, 10'h3FF, 48'h8000_0000_0000);
    send_op(OP_LOOKUP, 16'hFFFF, 21'h10FFFF, 10'h3FF, '0);
    send_op(OP_CLEAR, '0, '0, '0, '0);

    // random: small pool for hits, then a wider one that fills and evicts
    run_phase(250, 24, 0, 0);
    run_phase(250, KEY_POOL, 53, 0);
    run_phase(250, KEY_POOL, 0, 53);
    run_phase(250, KEY_POOL, 15, 15);
    run_phase(250, KEY_POOL, 0, 0);

    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d results: %0d lookup hits, %0d misses, %0d clears, %0d unused codes",
             results_seen, lookup_hits, lookup_misses, clears, idle_ops);
    $display("full cache evicted %0d times, %0d inserts replaced a held key",
             evictions, replacements);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/lkc_pkg.sv
hdl/lkc_ram.sv
hdl/lkc_ctrl.sv
hdl/lkc_dp.sv
hdl/lru_keyed_entry_cache.sv
tb/glyph_cache_checker.sv
tb/tb.sv
